### rtl/core/hss_pkg.sv
// ----------------------------------------------------------------------------
// hss_pkg: shared types, constants and tables of the harmonic sine synthesizer
// Widths, operation and register codes, the queued item and the quarter-wave
// sine table built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

   localparam int DEF_MAX_HARMONICS = 8;
   localparam int DEF_MAX_CHANNELS  = 8;
   localparam int DEF_PHASE_BITS    = 24;

   localparam int SINE_TABLE_BITS = 10;
   localparam int QUARTER_LEN     = 1 << SINE_TABLE_BITS;

   localparam int IDX_W   = 3;
   localparam int STEP_W  = 24;
   localparam int CHAN_W  = 3;
   localparam int SUM_W   = 16;
   localparam int MAG_W   = 15;
   localparam int VOL_W   = 15;
   localparam int PROD_W  = MAG_W + VOL_W;
   localparam int Q_SHIFT = 15;
   localparam int CFG_W   = 4;

   localparam int AMP_FULL   = 1 << 14;
   localparam int RESULT_CAP = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HARMONIC_COUNT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT  = 1'd1;

   localparam logic [CFG_W-1:0] HC_RESET = 4'd1;
   localparam logic [CFG_W-1:0] CC_RESET = 4'd2;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_GENERATE = 1'b1;

   typedef struct packed {
      logic              is_gen;
      logic              idx_ok;
      logic [IDX_W-1:0]  idx;
      logic [STEP_W-1:0] step;
      logic [STEP_W-1:0] offset;
   } hss_item_type;

   typedef logic [MAG_W-1:0] sine_rom_type [QUARTER_LEN + 1];

   // Taylor series of sin to the t^11 term in Q2.30, rounded to Q0.15
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type        rom;
      logic [63:0]         t;
      logic [63:0]         term;
      longint              acc;
      logic [63:0]         mag;
      for (int i = 0; i <= QUARTER_LEN; i++) begin
         t    = (HALF_PI_Q30 * 64'(i)) >> SINE_TABLE_BITS;
         term = t;
         acc  = longint'(t);
         term = (term * t) >> 30;
         term = (term * t) >> 30;
         term = term / 64'd6;
         acc  = acc - longint'(term);
         term = (term * t) >> 30;
         term = (term * t) >> 30;
         term = term / 64'd20;
         acc  = acc + longint'(term);
         term = (term * t) >> 30;
         term = (term * t) >> 30;
         term = term / 64'd42;
         acc  = acc - longint'(term);
         term = (term * t) >> 30;
         term = (term * t) >> 30;
         term = term / 64'd72;
         acc  = acc + longint'(term);
         term = (term * t) >> 30;
         term = (term * t) >> 30;
         term = term / 64'd110;
         acc  = acc - longint'(term);
         if (acc < 0) begin
            acc = 0;
         end
         mag    = ((64'(acc) * 64'd32767) + (64'd1 << 29)) >> 30;
         rom[i] = MAG_W'(mag);
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

### rtl/core/harmonic_sine_synthesizer.sv
// ----------------------------------------------------------------------------
// harmonic_sine_synthesizer: additive sine synthesizer top level
// Request queue in front, oscillator bank and mixer behind it, one output
// register towards the consumer.
// ----------------------------------------------------------------------------
//  Port group   Handshake          Contents
//  req_*        push / full        op, harmonic_index, phase_step, phase_offset
//  rsp_*        empty / pop        sample, channel, last
//  csr_*        csr_wr_en          csr_index, csr_wdata (no wait, no read-back)
//
//  A load request is executed as it leaves the two-entry queue. A generate
//  request leaves the queue, runs each harmonic through the shared sine table,
//  multiplier and adder, waits for that pipeline to drain, then emits one
//  sample per channel.
//  A stalled consumer holds the output register; requests still queue meanwhile.
//  Synchronous reset clears the accumulators to zero and the counts to 1 and 2.
// ----------------------------------------------------------------------------
`default_nettype none

module harmonic_sine_synthesizer #(
   parameter int MAX_HARMONICS = hss_pkg::DEF_MAX_HARMONICS,
   parameter int MAX_CHANNELS  = hss_pkg::DEF_MAX_CHANNELS,
   parameter int PHASE_BITS    = hss_pkg::DEF_PHASE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic                              req_op,
   input  logic [hss_pkg::IDX_W-1:0]         req_harmonic_index,
   input  logic [hss_pkg::STEP_W-1:0]        req_phase_step,
   input  logic [hss_pkg::STEP_W-1:0]        req_phase_offset,
   output logic                              empty,
   input  logic                              pop,
   output logic signed [hss_pkg::SUM_W-1:0]  rsp_sample,
   output logic [hss_pkg::CHAN_W-1:0]        rsp_channel,
   output logic                              rsp_last,
   input  logic                              csr_wr_en,
   input  logic [hss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hss_pkg::CFG_W-1:0]         csr_wdata
);
   import hss_pkg::*;

   logic         item_valid;
   logic         item_pop;
   hss_item_type item;

   hss_front #(
      .MAX_HARMONICS (MAX_HARMONICS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_op             (req_op),
      .req_harmonic_index (req_harmonic_index),
      .req_phase_step     (req_phase_step),
      .req_phase_offset   (req_phase_offset),
      .item_valid         (item_valid),
      .item_pop           (item_pop),
      .item               (item)
   );

   hss_back #(
      .MAX_HARMONICS (MAX_HARMONICS),
      .MAX_CHANNELS  (MAX_CHANNELS),
      .PHASE_BITS    (PHASE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_sample  (rsp_sample),
      .rsp_channel (rsp_channel),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

### rtl/core/hss_front.sv
// ----------------------------------------------------------------------------
// hss_front: request intake and classification
// Takes requests, tags them as load or generate, checks the table index and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_front #(
   parameter int MAX_HARMONICS = hss_pkg::DEF_MAX_HARMONICS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          req_op,
   input  logic [hss_pkg::IDX_W-1:0]     req_harmonic_index,
   input  logic [hss_pkg::STEP_W-1:0]    req_phase_step,
   input  logic [hss_pkg::STEP_W-1:0]    req_phase_offset,
   output logic                          item_valid,
   input  logic                          item_pop,
   output hss_pkg::hss_item_type         item
);
   import hss_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   hss_item_type           queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   hss_item_type           entry;
   logic                   do_push;
   logic                   do_pop;

   always_comb begin
      entry.is_gen = (req_op == OP_GENERATE);
      entry.idx_ok = (32'(req_harmonic_index) < MAX_HARMONICS);
      entry.idx    = req_harmonic_index;
      entry.step   = req_phase_step;
      entry.offset = req_phase_offset;
   end

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

### rtl/core/hss_back.sv
// ----------------------------------------------------------------------------
// hss_back: oscillator bank, mixer and frame output
// Executes queued requests: loads write the step and offset tables and clear
// the accumulators; generates run each harmonic through a four-stage lookup,
// scale and sum pipeline, then emit the frame once per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_back #(
   parameter int MAX_HARMONICS = hss_pkg::DEF_MAX_HARMONICS,
   parameter int MAX_CHANNELS  = hss_pkg::DEF_MAX_CHANNELS,
   parameter int PHASE_BITS    = hss_pkg::DEF_PHASE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [hss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [hss_pkg::CFG_W-1:0]         csr_wdata,
   input  logic                              item_valid,
   input  hss_pkg::hss_item_type             item,
   output logic                              item_pop,
   output logic                              empty,
   input  logic                              pop,
   output logic signed [hss_pkg::SUM_W-1:0]  rsp_sample,
   output logic [hss_pkg::CHAN_W-1:0]        rsp_channel,
   output logic                              rsp_last
);
   import hss_pkg::*;

   localparam int HIDX_W  = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
   localparam int HC_W    = $clog2(MAX_HARMONICS + 1);
   localparam int CHAN_HI = (MAX_CHANNELS < RESULT_CAP) ? MAX_CHANNELS : RESULT_CAP;
   localparam int TOP_W   = SINE_TABLE_BITS + 2;
   localparam int EXT_W   = (PHASE_BITS > TOP_W) ? PHASE_BITS : TOP_W;
   localparam int SHL     = EXT_W - PHASE_BITS;
   localparam int ADDR_W  = SINE_TABLE_BITS + 1;

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [CFG_W-1:0]           harmonic_count_ff, channel_count_ff;
   logic [HC_W-1:0]            hc_clamped, hc_ff;
   logic [CFG_W-1:0]           cc_clamped, cc_ff;
   logic [VOL_W-1:0]           vol_tab [MAX_HARMONICS];
   logic [VOL_W-1:0]           vol_ff;

   logic [PHASE_BITS-1:0]      step_mem [MAX_HARMONICS];
   logic [PHASE_BITS-1:0]      off_mem  [MAX_HARMONICS];
   logic [PHASE_BITS-1:0]      acc_mem  [MAX_HARMONICS];
   logic [MAX_HARMONICS-1:0]   acc_vld_ff;

   logic [HIDX_W-1:0]          h_ff;
   logic [CHAN_W-1:0]          k_ff;

   logic                       s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [HIDX_W-1:0]          s1_idx_ff;
   logic [PHASE_BITS-1:0]      step_q_ff, off_q_ff, acc_q_ff;
   logic                       accv_q_ff;
   logic [MAG_W-1:0]           rom_q_ff;
   logic                       neg1_ff, neg2_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic signed [SUM_W-1:0]    sum_ff;

   logic                       out_vld_ff;
   logic signed [SUM_W-1:0]    sample_ff;
   logic [CHAN_W-1:0]          channel_ff;
   logic                       last_ff;

   logic                       load_clr, load_wr, gen_start, issue, last_issue;
   logic                       pipe_busy, emit, k_last;
   logic [PHASE_BITS-1:0]      acc_eff, phase;
   logic [EXT_W-1:0]           phase_ext;
   logic [TOP_W-1:0]           tap;
   logic [1:0]                 quad;
   logic [SINE_TABLE_BITS-1:0] frac;
   logic [ADDR_W-1:0]          rom_addr;
   logic [MAG_W-1:0]           term;

   for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_vol
      localparam int VOLUME = AMP_FULL / (g + 1);
      assign vol_tab[g] = VOL_W'(VOLUME);
   end

   always_comb begin
      if (harmonic_count_ff == '0) begin
         hc_clamped = HC_W'(1);
      end else if (32'(harmonic_count_ff) > MAX_HARMONICS) begin
         hc_clamped = HC_W'(MAX_HARMONICS);
      end else begin
         hc_clamped = HC_W'(harmonic_count_ff);
      end
      if (channel_count_ff == '0) begin
         cc_clamped = CFG_W'(1);
      end else if (32'(channel_count_ff) > CHAN_HI) begin
         cc_clamped = CFG_W'(CHAN_HI);
      end else begin
         cc_clamped = channel_count_ff;
      end
   end

   assign item_pop   = (state_ff == ST_IDLE) && item_valid;
   assign load_clr   = item_pop && !item.is_gen;
   assign load_wr    = load_clr && item.idx_ok;
   assign gen_start  = item_pop && item.is_gen;
   assign issue      = (state_ff == ST_RUN);
   assign last_issue = issue && (h_ff == HIDX_W'(hc_ff - HC_W'(1)));
   assign pipe_busy  = s1_vld_ff || s2_vld_ff || s3_vld_ff;
   assign emit       = (state_ff == ST_EMIT) && (!out_vld_ff || pop);
   assign k_last     = ({1'b0, k_ff} == (cc_ff - CFG_W'(1)));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (gen_start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit && k_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // phase to quarter-wave address
   always_comb begin
      acc_eff   = accv_q_ff ? acc_q_ff : '0;
      phase     = acc_eff + off_q_ff;
      phase_ext = EXT_W'(phase) << SHL;
      tap       = phase_ext[EXT_W-1 -: TOP_W];
      quad      = tap[TOP_W-1 -: 2];
      frac      = tap[SINE_TABLE_BITS-1:0];
      rom_addr  = quad[0] ? (ADDR_W'(QUARTER_LEN) - {1'b0, frac}) : {1'b0, frac};
      term      = MAG_W'(prod_ff >> Q_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         harmonic_count_ff <= HC_RESET;
         channel_count_ff  <= CC_RESET;
         acc_vld_ff        <= '0;
         s1_vld_ff         <= 1'b0;
         s2_vld_ff         <= 1'b0;
         s3_vld_ff         <= 1'b0;
         out_vld_ff        <= 1'b0;
         h_ff              <= '0;
         k_ff              <= '0;
      end else begin
         state_ff  <= state_in;
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_HARMONIC_COUNT: harmonic_count_ff <= csr_wdata;
               CSR_CHANNEL_COUNT:  channel_count_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (load_clr) begin
            acc_vld_ff <= '0;
         end else if (s1_vld_ff) begin
            acc_vld_ff[s1_idx_ff] <= 1'b1;
         end
         if (gen_start) begin
            h_ff <= '0;
         end else if (issue) begin
            h_ff <= h_ff + HIDX_W'(1);
         end
         if (gen_start) begin
            k_ff <= '0;
         end else if (emit) begin
            k_ff <= k_ff + CHAN_W'(1);
         end
         if (emit) begin
            out_vld_ff <= 1'b1;
         end else if (pop) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_wr) begin
         step_mem[HIDX_W'(item.idx)] <= PHASE_BITS'(item.step);
         off_mem[HIDX_W'(item.idx)]  <= PHASE_BITS'(item.offset);
      end
      step_q_ff <= step_mem[h_ff];
      off_q_ff  <= off_mem[h_ff];
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         acc_mem[s1_idx_ff] <= acc_eff + step_q_ff;
      end
      acc_q_ff <= acc_mem[h_ff];
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_ROM[rom_addr];
   end

   always_ff @(posedge clock) begin
      accv_q_ff <= acc_vld_ff[h_ff];
      s1_idx_ff <= h_ff;
      neg1_ff   <= quad[1];
      neg2_ff   <= neg1_ff;
      prod_ff   <= PROD_W'(rom_q_ff) * PROD_W'(vol_ff);
      if (gen_start) begin
         hc_ff  <= hc_clamped;
         cc_ff  <= cc_clamped;
         vol_ff <= vol_tab[HIDX_W'(hc_clamped - HC_W'(1))];
         sum_ff <= '0;
      end else if (s3_vld_ff) begin
         sum_ff <= neg2_ff ? (sum_ff - SUM_W'(term)) : (sum_ff + SUM_W'(term));
      end
      if (emit) begin
         sample_ff  <= sum_ff;
         channel_ff <= k_ff;
         last_ff    <= k_last;
      end
   end

   assign empty       = !out_vld_ff;
   assign rsp_sample  = sample_ff;
   assign rsp_channel = channel_ff;
   assign rsp_last    = last_ff;

endmodule

`default_nettype wire

### rtl/core/hss_checker.sv
// ----------------------------------------------------------------------------
// hss_checker: port-level checks of the harmonic sine synthesizer
// Frame ordering, constant frame sample, reset state and output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              full,
   input  logic                              empty,
   input  logic                              pop,
   input  logic signed [hss_pkg::SUM_W-1:0]  rsp_sample,
   input  logic [hss_pkg::CHAN_W-1:0]        rsp_channel,
   input  logic                              rsp_last
);
   import hss_pkg::*;

   logic [CHAN_W-1:0]       exp_chan_ff;
   logic signed [SUM_W-1:0] frame_sample_ff;
   logic                    taken;

   assign taken = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_chan_ff <= '0;
      end else if (taken) begin
         exp_chan_ff <= rsp_last ? '0 : rsp_channel + CHAN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (taken && (rsp_channel == '0)) begin
         frame_sample_ff <= rsp_sample;
      end
   end

   a_reset_state: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_channel_order: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_channel == exp_chan_ff))
      else $error("channel out of sequence");

   a_frame_sample: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_channel != '0)) |-> (rsp_sample == frame_sample_ff))
      else $error("sample differs within a frame");

   a_hold_output: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_sample) && $stable(rsp_channel)
                            && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind harmonic_sine_synthesizer hss_checker u_hss_checker (
   .clock       (clock),
   .reset       (reset),
   .full        (full),
   .empty       (empty),
   .pop         (pop),
   .rsp_sample  (rsp_sample),
   .rsp_channel (rsp_channel),
   .rsp_last    (rsp_last)
);

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the harmonic sine synthesizer
// Drives load and generate requests through the request queue, pops the
// channel samples at random rates, and compares every sample, channel number
// and last flag against a bit-true oscillator bank kept in a scoreboard class.
// Runs several harmonic and channel count settings, including both extremes
// and out-of-range values, and holds the consumer off long enough to
// back-pressure the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import hss_pkg::*;

   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 32;

   typedef struct {
      logic signed [15:0] sample;
      logic [2:0]         channel;
      logic               last;
   } channel_sample_type;

   class synth_scoreboard;
      logic [23:0]        step_tbl [8];
      logic [23:0]        offset_tbl [8];
      logic [23:0]        phase_acc [8];
      logic [3:0]         harm_count;
      logic [3:0]         chan_count;
      int                 sine_mag [1025];
      channel_sample_type expected_samples [$];
      int                 errors;
      int                 requests;
      int                 frames;
      int                 checked;

      function new();
         longint unsigned t;
         longint unsigned term;
         longint          acc;
         for (int i = 0; i <= 1024; i++) begin
            t    = (64'd1686629713 * 64'(i)) >> 10;
            term = t;
            acc  = longint'(t);
            for (int k = 1; k <= 5; k++) begin
               term = (term * t) >> 30;
               term = (term * t) >> 30;
               term = term / 64'((2 * k) * (2 * k + 1));
               if (k % 2 == 1) begin
                  acc = acc - longint'(term);
               end else begin
                  acc = acc + longint'(term);
               end
            end
            if (acc < 0) begin
               acc = 0;
            end
            sine_mag[i] = int'((acc * 32767 + (64'd1 << 29)) >> 30);
         end
         foreach (phase_acc[h]) begin
            step_tbl[h]   = '0;
            offset_tbl[h] = '0;
            phase_acc[h]  = '0;
         end
         harm_count = 4'd1;
         chan_count = 4'd2;
         errors     = 0;
         requests   = 0;
         frames     = 0;
         checked    = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [3:0] value);
         if (index == CSR_HARMONIC_COUNT) begin
            harm_count = value;
         end else if (index == CSR_CHANNEL_COUNT) begin
            chan_count = value;
         end
      endfunction

      function void note_request(logic op, logic [2:0] idx, logic [23:0] step,
                                 logic [23:0] offset);
         int                 hc;
         int                 cc;
         int                 vol;
         int                 sum;
         int                 mag;
         int                 term;
         int                 f;
         logic [23:0]        ph;
         channel_sample_type s;
         requests++;
         if (op == OP_LOAD) begin
            step_tbl[idx]   = step;
            offset_tbl[idx] = offset;
            foreach (phase_acc[h]) begin
               phase_acc[h] = '0;
            end
            return;
         end
         frames++;
         hc  = (harm_count == 0) ? 1 : ((harm_count > 8) ? 8 : int'(harm_count));
         cc  = (chan_count == 0) ? 1 : ((chan_count > 8) ? 8 : int'(chan_count));
         vol = 16384 / hc;
         sum = 0;
         for (int h = 0; h < hc; h++) begin
            ph   = phase_acc[h] + offset_tbl[h];
            f    = int'(ph[21:12]);
            mag  = ph[22] ? sine_mag[1024 - f] : sine_mag[f];
            term = (mag * vol) >> 15;
            sum  = ph[23] ? sum - term : sum + term;
            phase_acc[h] = phase_acc[h] + step_tbl[h];
         end
         for (int k = 0; k < cc; k++) begin
            s.sample  = 16'(sum);
            s.channel = 3'(k);
            s.last    = (k == cc - 1);
            expected_samples.insert(expected_samples.size(), s);
         end
      endfunction

      function void check_sample(logic signed [15:0] sample, logic [2:0] channel,
                                 logic last);
         channel_sample_type s;
         if (expected_samples.size() == 0) begin
            $error("unexpected sample %0d on channel %0d", sample, channel);
            errors++;
            return;
         end
         s = expected_samples.pop_front();
         checked++;
         if (sample !== s.sample) begin
            $error("sample: expected %0d, got %0d", s.sample, sample);
            errors++;
         end
         if (channel !== s.channel) begin
            $error("channel: expected %0d, got %0d", s.channel, channel);
            errors++;
         end
         if (last !== s.last) begin
            $error("last: expected %0d, got %0d", s.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    push = 1'b0;
   logic                    full;
   logic                    req_op = OP_LOAD;
   logic [IDX_W-1:0]        req_harmonic_index = '0;
   logic [STEP_W-1:0]       req_phase_step = '0;
   logic [STEP_W-1:0]       req_phase_offset = '0;
   logic                    empty;
   logic                    pop = 1'b0;
   logic signed [SUM_W-1:0] rsp_sample;
   logic [CHAN_W-1:0]       rsp_channel;
   logic                    rsp_last;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]        csr_wdata = '0;

   synth_scoreboard sb = new();
   int              send_streak = 0;
   bit              hold_consumer = 1'b0;
   int              full_cycles = 0;

   harmonic_sine_synthesizer i_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_op             (req_op),
      .req_harmonic_index (req_harmonic_index),
      .req_phase_step     (req_phase_step),
      .req_phase_offset   (req_phase_offset),
      .empty              (empty),
      .pop                (pop),
      .rsp_sample         (rsp_sample),
      .rsp_channel        (rsp_channel),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (push && full) begin
         full_cycles++;
      end
   end

   // mostly random gaps, now and then a burst with none
   function automatic int pick_gap(ref int streak);
      if (streak > 0) begin
         streak--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         streak = $urandom_range(5, 30);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   task automatic send_request(logic op, logic [2:0] idx, logic [23:0] step,
                               logic [23:0] offset);
      int gap;
      gap = pick_gap(send_streak);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push               <= 1'b1;
      req_op             <= op;
      req_harmonic_index <= idx;
      req_phase_step     <= step;
      req_phase_offset   <= offset;
      do @(posedge clock); while (full);
      sb.note_request(op, idx, step, offset);
   endtask

   task automatic send_frame();
      send_request(OP_GENERATE, 3'($urandom()), 24'($urandom()), 24'($urandom()));
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] index, logic [3:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(index, value);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : consumer
      int streak;
      int gap;
      streak = 0;
      wait (!reset);
      forever begin
         if (hold_consumer) begin
            hold_consumer = 1'b0;
            gap = LONG_HOLD;
         end else begin
            gap = pick_gap(streak);
         end
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         sb.check_sample(rsp_sample, rsp_channel, rsp_last);
      end
   end

   initial begin : stimulus
      int          hc_set [6];
      int          cc_set [6];
      logic [23:0] step;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // silent oscillator, then a quarter-turn step through all four quadrants
      send_request(OP_LOAD, 3'd0, 24'h000000, 24'h000000);
      send_frame();
      send_request(OP_LOAD, 3'd0, 24'h400000, 24'h000000);
      repeat (4) send_frame();
      // full-scale step and offset: phase wraps on every frame
      send_request(OP_LOAD, 3'd0, 24'hFFFFFF, 24'hFFFFFF);
      repeat (2) send_frame();
      for (int i = 1; i < 7; i++) begin
         send_request(OP_LOAD, 3'(i), 24'($urandom()), 24'($urandom()));
      end
      send_request(OP_LOAD, 3'd7, 24'h000001, 24'h800000);
      wait_idle();
      write_register(CSR_HARMONIC_COUNT, 4'd8);
      write_register(CSR_CHANNEL_COUNT, 4'd8);
      repeat (3) send_frame();

      hc_set = '{8, 1, 0, 15, 4, $urandom_range(0, 15)};
      cc_set = '{8, 1, 0, 15, 3, $urandom_range(0, 15)};
      for (int p = 0; p < 6; p++) begin
         wait_idle();
         write_register(CSR_HARMONIC_COUNT, 4'(hc_set[p]));
         write_register(CSR_CHANNEL_COUNT, 4'(cc_set[p]));
         if (p == 0) begin
            hold_consumer = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 4) == 0) begin
               case ($urandom_range(0, 3))
                  0: step = 24'($urandom_range(0, 4095));
                  1: step = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
                  default: step = 24'($urandom());
               endcase
               send_request(OP_LOAD, 3'($urandom()), step, 24'($urandom()));
            end else begin
               send_frame();
            end
         end
      end
      wait_idle();

      $display("Covered %0d requests (%0d frames) over six count settings,",
               sb.requests, sb.frames);
      $display("%0d channel samples checked, request side held off for %0d cycles",
               sb.checked, full_cycles);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/hss_pkg.sv
rtl/core/hss_front.sv
rtl/core/hss_back.sv
rtl/core/harmonic_sine_synthesizer.sv
rtl/core/hss_checker.sv
bench/tb_top.sv
